// ===== hdl/cssc_pkg.sv =====
// Shared constants, register indexes and types for the cross stencil star counter.
package cssc_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIX_W      = 8;
    localparam int STAR_W     = 22;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    // five 8-bit values summed, and five times an 8-bit threshold
    localparam int SUM_W      = 11;

    localparam logic [STAR_W-1:0] STAR_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_THRESHOLD = 2'd2;

    localparam logic [IMG_W_W-1:0] IMG_W_RST = 11'd8;
    localparam logic [IMG_H_W-1:0] IMG_H_RST = 13'd6;
    localparam logic [THR_W-1:0]   THR_RST   = 8'd6;

endpackage

// ===== hdl/cssc_pixel_if.sv =====
// Pixel input channel: valid, ready and one pixel per beat.
interface cssc_pixel_if import cssc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ===== hdl/cssc_star_if.sv =====
// Result channel: valid, ready and the star total of one frame per beat.
interface cssc_star_if import cssc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAR_W-1:0] star_total;

    modport source (output valid, output star_total, input ready);
    modport sink   (input valid, input star_total, output ready);
endinterface

// ===== hdl/cssc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cssc_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/cross_stencil_star_counter.sv =====
// Five-point cross stencil star counter: top level.
//
// Pixels enter on i_pixel (valid/ready), one per beat, in raster order. For
// every interior pixel the block adds the pixel and its four cross neighbors
// and counts a star when the sum exceeds five times avg_threshold. At the last
// pixel of a frame one beat carrying the frame's star total leaves on o_star.
// Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data: index 0 is
// image_width, 1 is image_height, 2 is avg_threshold. Sizes are clamped to
// 3..MAX_WIDTH and 3..MAX_HEIGHT.
//
// Throughput is one pixel per clock while the input is not held off. A pixel
// is accepted in stage 1, while its line-store entries are read from the two
// RAMs (one read port each, registered read data); stage 2 then does the sum,
// the compare and the write-back. The star total is registered and shown on
// o_star once the last pixel of the frame has left stage 2.
// While the total waits in the output register, pixels keep flowing; input is
// held off only when the next frame end arrives while that total is still not
// taken. Reset clears positions, window, counter and registers to defaults;
// the line stores need no clearing pass, as every entry that feeds a test is
// written in the first two rows of the frame.
module cross_stencil_star_counter import cssc_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cssc_pixel_if.sink            i_pixel,
    cssc_star_if.source           o_star
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [PIX_W-1:0]   pixel;
        logic               test;
        logic               last_col;
        logic               frame_end;
        logic               fwd_pair;
        logic [2*PIX_W-1:0] fwd_pair_data;
        logic               fwd_ahead;
        logic [PIX_W-1:0]   fwd_ahead_data;
    } t_s2;

    // configuration
    logic [IMG_W_W-1:0] r_image_width;
    logic [IMG_H_W-1:0] r_image_height;
    logic [THR_W-1:0]   r_avg_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= IMG_W_RST;
            r_image_height  <= IMG_H_RST;
            r_avg_threshold <= THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data[IMG_H_W-1:0];
                CFG_AVG_THRESHOLD: r_avg_threshold <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // effective last column and row
    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;

    always_comb begin
        if (r_image_width < 11'd3) begin
            w_last = COL_W'(2);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_last = COL_W'(r_image_width - 11'd1);
        end
        if (r_image_height < 13'd3) begin
            h_last = ROW_W'(2);
        end else if (32'(r_image_height) > MAX_HEIGHT) begin
            h_last = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            h_last = ROW_W'(r_image_height - 13'd1);
        end
    end

    // stage 1: position and line-store read
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   c_eff;
    logic [ROW_W-1:0]   row_eff;
    logic               last_col;
    logic               last_row;
    logic [COL_W-1:0]   ahead_addr;
    logic               acc_in;
    logic               stall2;
    logic               s2_adv;

    logic               r_s2_valid;
    t_s2                r_s2, n_s2;

    logic [2*PIX_W-1:0] pair_rdata;
    logic [PIX_W-1:0]   ahead_rdata;
    logic [2*PIX_W-1:0] pair_wdata;

    logic               r_out_valid;
    logic [STAR_W-1:0]  r_out_star;

    assign c_eff      = (r_col > w_last) ? w_last : r_col;
    assign row_eff    = (r_row > h_last) ? h_last : r_row;
    assign last_col   = (c_eff == w_last);
    assign last_row   = (row_eff == h_last);
    assign ahead_addr = last_col ? c_eff : c_eff + 1'b1;

    assign stall2        = r_s2_valid && r_s2.frame_end && r_out_valid && !o_star.ready;
    assign s2_adv        = r_s2_valid && !stall2;
    assign i_pixel.ready = !stall2;
    assign acc_in        = i_pixel.valid && !stall2;

    always_comb begin
        n_col = c_eff + 1'b1;
        n_row = row_eff;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : row_eff + 1'b1;
        end
    end

    always_comb begin
        n_s2.col            = c_eff;
        n_s2.pixel          = i_pixel.pixel;
        n_s2.test           = (row_eff >= ROW_W'(2)) && (c_eff != '0) && !last_col;
        n_s2.last_col       = last_col;
        n_s2.frame_end      = last_col && last_row;
        // write-back of the item ahead lands in this same cycle
        n_s2.fwd_pair       = s2_adv && (r_s2.col == c_eff);
        n_s2.fwd_pair_data  = pair_wdata;
        n_s2.fwd_ahead      = s2_adv && (r_s2.col == ahead_addr);
        n_s2.fwd_ahead_data = r_s2.pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            if (acc_in) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (acc_in) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_s2 <= n_s2;
        end
    end

    // line stores: {upper, middle} at c, and a copy of middle read one column ahead
    cssc_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (s2_adv),
        .i_waddr (r_s2.col),
        .i_wdata (pair_wdata),
        .i_re    (acc_in),
        .i_raddr (c_eff),
        .o_rdata (pair_rdata)
    );

    cssc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_ahead_ram (
        .i_clk   (i_clk),
        .i_we    (s2_adv),
        .i_waddr (r_s2.col),
        .i_wdata (r_s2.pixel),
        .i_re    (acc_in),
        .i_raddr (ahead_addr),
        .o_rdata (ahead_rdata)
    );

    // stage 2: stencil sum, compare, write-back
    logic [2*PIX_W-1:0] pair_cur;
    logic [PIX_W-1:0]   up_cur;
    logic [PIX_W-1:0]   mid_cur;
    logic [PIX_W-1:0]   right_cur;
    logic [PIX_W-1:0]   r_left;
    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   limit;
    logic               star_hit;
    logic [STAR_W-1:0]  r_acc;

    assign pair_cur   = r_s2.fwd_pair ? r_s2.fwd_pair_data : pair_rdata;
    assign up_cur     = pair_cur[2*PIX_W-1:PIX_W];
    assign mid_cur    = pair_cur[PIX_W-1:0];
    assign right_cur  = r_s2.last_col  ? '0 :
                        r_s2.fwd_ahead ? r_s2.fwd_ahead_data : ahead_rdata;
    // upper gets the old middle, middle gets the new pixel
    assign pair_wdata = {mid_cur, r_s2.pixel};

    assign sum = SUM_W'(r_left) + SUM_W'(mid_cur) + SUM_W'(right_cur)
               + SUM_W'(up_cur) + SUM_W'(r_s2.pixel);
    assign limit    = SUM_W'({r_avg_threshold, 2'b00}) + SUM_W'(r_avg_threshold);
    assign star_hit = r_s2.test && (sum > limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s2_adv) begin
                r_left <= mid_cur;
                if (r_s2.frame_end) begin
                    r_acc <= '0;
                end else if (star_hit && (r_acc != STAR_MAX)) begin
                    r_acc <= r_acc + 1'b1;
                end
            end
            if (s2_adv && r_s2.frame_end) begin
                r_out_valid <= 1'b1;
            end else if (o_star.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s2.frame_end) begin
            r_out_star <= r_acc;
        end
    end

    assign o_star.valid      = r_out_valid;
    assign o_star.star_total = r_out_star;

    // checks
    a_result_from_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s2_adv && r_s2.frame_end))
        else $error("result raised without a frame end");

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && stall2) |=> (r_s2_valid && $stable(r_s2.col) && $stable(r_acc)))
        else $error("stage 2 moved while stalled");

    a_counter_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_adv && r_s2.frame_end) |=> (r_acc == '0))
        else $error("star counter not cleared at frame end");

    a_test_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2.test) |-> ((r_s2.col != '0) && !r_s2.last_col && !r_s2.frame_end))
        else $error("border pixel marked for test");

endmodule

// ===== bench/cssc_star_checker.sv =====
// Checker for the cross stencil star counter: tracks registers, predicts frame totals, compares.
module cssc_star_checker import cssc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_pix_valid,
    input  logic                  i_pix_ready,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_star_valid,
    input  logic                  i_star_ready,
    input  logic [STAR_W-1:0]     i_star_total,
    output int                    o_pending,
    output int                    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COL_W          = $clog2(MAX_WIDTH_DEF);
    localparam int ROW_W          = $clog2(MAX_HEIGHT_DEF);
    localparam int STENCIL_POINTS = 5;

    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [THR_W-1:0]   thr_reg;

    logic [PIX_W-1:0]  upper_line  [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]  middle_line [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]  win_left, win_mid, win_right;
    logic [COL_W-1:0]  col_pos;
    logic [ROW_W-1:0]  row_pos;
    logic [STAR_W-1:0] star_count;
    logic [STAR_W-1:0] totals_due [$];
    int                fails = 0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    // Consume one pixel: test the middle-row pixel above it, then slide the line stores.
    task automatic advance_stencil(input logic [PIX_W-1:0] px);
        int unsigned      w, h, c, r;
        logic             at_last_col, at_last_row;
        logic [PIX_W-1:0] above;
        logic [SUM_W-1:0] cross_sum;
        w = clamp_dim(width_reg, MAX_WIDTH_DEF);
        h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
        // a position past a shrunk size counts as the last one
        c = (col_pos > w - 1) ? w - 1 : col_pos;
        r = (row_pos > h - 1) ? h - 1 : row_pos;
        at_last_col = (c == w - 1);
        at_last_row = (r == h - 1);

        win_left  = win_mid;
        win_mid   = middle_line[c];
        win_right = at_last_col ? '0 : middle_line[c + 1];
        above     = upper_line[c];

        if (r >= 2 && c >= 1 && !at_last_col) begin
            cross_sum = win_left + win_mid + win_right + above + px;
            if (cross_sum > STENCIL_POINTS * thr_reg && star_count != STAR_MAX)
                star_count = star_count + 1'b1;
        end

        upper_line[c]  = middle_line[c];
        middle_line[c] = px;

        if (at_last_col) begin
            col_pos = '0;
            if (at_last_row) begin
                totals_due.push_back(star_count);
                star_count = '0;
                row_pos    = '0;
            end else begin
                row_pos = ROW_W'(r + 1);
            end
        end else begin
            col_pos = COL_W'(c + 1);
            row_pos = ROW_W'(r);
        end
    endtask

    always @(posedge i_clk) begin : track
        logic [STAR_W-1:0] oldest;
        if (!i_rst_n) begin
            width_reg  = IMG_W_RST;
            height_reg = IMG_H_RST;
            thr_reg    = THR_RST;
            win_left   = '0;
            win_mid    = '0;
            win_right  = '0;
            col_pos    = '0;
            row_pos    = '0;
            star_count = '0;
            totals_due.delete();
            for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
        end else begin
            // an older frame's total can leave on the edge that ends the next frame
            if (i_star_valid && i_star_ready) begin
                if (totals_due.size() == 0) begin
                    $error("star_total: beat with nothing expected, actual %0d", i_star_total);
                    fails++;
                end else begin
                    oldest = totals_due.pop_front();
                    if (i_star_total !== oldest) begin
                        $error("star_total mismatch: expected %0d, actual %0d",
                               oldest, i_star_total);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IMAGE_WIDTH:   width_reg  = i_cfg_data[IMG_W_W-1:0];
                    CFG_IMAGE_HEIGHT:  height_reg = i_cfg_data[IMG_H_W-1:0];
                    CFG_AVG_THRESHOLD: thr_reg    = i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix_valid && i_pix_ready)
                advance_stencil(i_pixel);
        end
        o_pending    <= totals_due.size();
        o_fail_count <= fails;
    end

endmodule

// ===== bench/tb_cross_stencil_star_counter.sv =====
// Stimulus and verdict for the cross stencil star counter.
module tb_cross_stencil_star_counter import cssc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_GAP       = 9;
    localparam int          DRAIN_CYCLES  = 6;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          NEAR_SPAN     = 8;
    localparam int          RANDOM_ITEMS  = 300;
    localparam int          MIN_FRAMES    = 8;
    localparam int unsigned TIMEOUT_NS    = 400_000;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef enum {PX_FLAT, PX_NEAR, PX_NOISE, PX_ALT} t_pix_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int totals_pending;
    int fail_count;
    bit src_calm;
    bit sink_calm;
    bit hold_off_req;

    cssc_pixel_if pix_if ();
    cssc_star_if  star_if ();

    cross_stencil_star_counter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pixel    (pix_if),
        .o_star     (star_if)
    );

    cssc_star_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_pix_valid  (pix_if.valid),
        .i_pix_ready  (pix_if.ready),
        .i_pixel      (pix_if.pixel),
        .i_star_valid (star_if.valid),
        .i_star_ready (star_if.ready),
        .i_star_total (star_if.star_total),
        .o_pending    (totals_pending),
        .o_fail_count (fail_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // Keep valid high across back-to-back beats; lower it only for a real gap.
    task automatic send_pixels(input int unsigned count, input t_pix_mode mode,
                               input logic [PIX_W-1:0] level);
        logic [PIX_W-1:0] value;
        int               gap, lo, hi;
        lo = (level < NEAR_SPAN) ? 0 : level - NEAR_SPAN;
        hi = (level + NEAR_SPAN > 255) ? 255 : level + NEAR_SPAN;
        for (int unsigned k = 0; k < count; k++) begin
            case (mode)
                PX_FLAT:  value = level;
                PX_NEAR:  value = PIX_W'($urandom_range(hi, lo));
                PX_ALT:   value = k[0] ? '1 : '0;
                default:  value = PIX_W'($urandom_range(0, 255));
            endcase
            gap = src_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pix_if.valid <= 1'b1;
            pix_if.pixel <= value;
            do @(posedge i_clk); while (!(pix_if.valid && pix_if.ready));
        end
    endtask

    // Drop valid, wait for every frame total, then let the pipeline empty.
    task automatic quiesce();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (totals_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [CFG_DATA_W-1:0] w_data,
                               input logic [CFG_DATA_W-1:0] h_data,
                               input logic [CFG_DATA_W-1:0] thr_data);
        quiesce();
        write_reg(CFG_IMAGE_WIDTH, w_data);
        write_reg(CFG_IMAGE_HEIGHT, h_data);
        write_reg(CFG_AVG_THRESHOLD, thr_data);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_reg_idle(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        quiesce();
        write_reg(idx, data);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : result_sink
        int gap;
        star_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                star_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            gap = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                star_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            star_if.ready <= 1'b1;
            do @(posedge i_clk);
            while (!(star_if.valid && star_if.ready) && !hold_off_req);
        end
    end

    initial begin : stimulus
        int unsigned      w_val, h_val, frame_px, split, random_items, random_frames;
        logic [CFG_DATA_W-1:0] w_data, thr_data;
        logic [PIX_W-1:0] level;
        t_pix_mode        mode;
        bit               first;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_IMAGE_WIDTH;
        i_cfg_data   <= '0;
        pix_if.valid <= 1'b0;
        pix_if.pixel <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults after reset: 8x6 frame, threshold 6
        send_pixels(48, PX_NEAR, 8'd6);

        // sum equal to five times the threshold is not a star
        reconfigure(3, 3, 0);
        send_pixels(9, PX_FLAT, 8'd0);
        send_pixels(9, PX_FLAT, 8'd1);

        // sizes below range clamp to 3
        reconfigure(0, 2, 100);
        send_pixels(9, PX_FLAT, 8'd100);
        send_pixels(9, PX_FLAT, 8'd101);
        reconfigure(1, 0, 0);
        send_pixels(9, PX_NOISE, 8'd0);
        reconfigure(2, 1, 50);
        send_pixels(9, PX_ALT, 8'd0);

        // top threshold can never fire; one below fires on full white
        reconfigure(4, 4, 255);
        send_pixels(16, PX_FLAT, 8'd255);
        set_reg_idle(CFG_AVG_THRESHOLD, 254);
        send_pixels(16, PX_FLAT, 8'd255);

        // bits above each register's width are dropped
        reconfigure(13'h1805, 5, 13'h1F80);
        send_pixels(25, PX_NEAR, 8'd128);
        set_reg_idle(CFG_UNUSED_IDX, '1);
        send_pixels(25, PX_NEAR, 8'd128);

        // threshold change in mid-frame
        reconfigure(6, 6, 40);
        send_pixels(15, PX_NEAR, 8'd40);
        set_reg_idle(CFG_AVG_THRESHOLD, 60);
        send_pixels(21, PX_NEAR, 8'd60);

        // width shrinks at row 2 column 5: that pixel closes the row
        reconfigure(8, 6, 20);
        send_pixels(21, PX_NEAR, 8'd20);
        set_reg_idle(CFG_IMAGE_WIDTH, 4);
        send_pixels(13, PX_NEAR, 8'd20);

        // height shrinks at row 5: that row becomes the last one
        reconfigure(5, 8, 20);
        send_pixels(25, PX_NEAR, 8'd20);
        set_reg_idle(CFG_IMAGE_HEIGHT, 3);
        send_pixels(5, PX_NEAR, 8'd20);

        // width above range clamps to the widest row: row 0 closes after
        // MAX_WIDTH_DEF pixels, then shrink to 3 at row 1 column 1
        reconfigure(2047, 3, 128);
        send_pixels(MAX_WIDTH_DEF + 1, PX_NOISE, 8'd0);
        set_reg_idle(CFG_IMAGE_WIDTH, 3);
        send_pixels(5, PX_NOISE, 8'd0);

        // hold off the result side so frame totals back up into the input
        reconfigure(3, 3, 0);
        hold_off_req = 1'b1;
        src_calm     = 1'b1;
        send_pixels(12 * 9, PX_NOISE, 8'd0);
        src_calm     = 1'b0;

        first         = 1'b1;
        random_items  = 0;
        random_frames = 0;
        frame_px      = 9;
        level         = '0;
        while (random_items < RANDOM_ITEMS || random_frames < MIN_FRAMES) begin
            if (first || $urandom_range(0, 2) == 0) begin
                w_val    = $urandom_range(0, 12);
                h_val    = $urandom_range(0, 8);
                w_data   = CFG_DATA_W'(w_val) |
                           (CFG_DATA_W'($urandom_range(0, 3)) << IMG_W_W);
                thr_data = CFG_DATA_W'($urandom_range(0, 8191));
                reconfigure(w_data, CFG_DATA_W'(h_val), thr_data);
                frame_px = (w_val < 3 ? 3 : w_val) * (h_val < 3 ? 3 : h_val);
                level    = thr_data[THR_W-1:0];
                first    = 1'b0;
            end
            src_calm  = ($urandom_range(0, 5) == 0);
            sink_calm = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 5))
                0:       mode = PX_NOISE;
                1:       mode = PX_ALT;
                default: mode = PX_NEAR;
            endcase
            if ($urandom_range(0, 7) == 0) begin
                split = $urandom_range(1, frame_px - 1);
                send_pixels(split, mode, level);
                level = PIX_W'($urandom_range(0, 255));
                set_reg_idle(CFG_AVG_THRESHOLD, CFG_DATA_W'(level));
                send_pixels(frame_px - split, mode, level);
            end else begin
                send_pixels(frame_px, mode, level);
            end
            random_items  += frame_px;
            random_frames += 1;
        end
        src_calm  = 1'b0;
        sink_calm = 1'b0;

        quiesce();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== cross_stencil_star_counter.f =====
hdl/cssc_pkg.sv
hdl/cssc_pixel_if.sv
hdl/cssc_star_if.sv
hdl/cssc_ram.sv
hdl/cross_stencil_star_counter.sv
bench/cssc_star_checker.sv
bench/tb_cross_stencil_star_counter.sv
